// ----- hdl/button_click_hold_classifier_assert.svh -----
// Assertion macros shared by the button classifier RTL.
`ifndef BUTTON_CLICK_HOLD_CLASSIFIER_ASSERT_SVH
`define BUTTON_CLICK_HOLD_CLASSIFIER_ASSERT_SVH

// Checks that a condition holds at every rising clock edge outside reset.
`define BCHC_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Checks that the consequent holds in the same cycle as the antecedent.
`define BCHC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define BCHC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/bchc_pkg.sv -----
// Package with the types and constants of the button click and hold classifier.
`timescale 1ns / 1ps

package bchc_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned MsW = 16;
	localparam int unsigned CfgIdxW = 2;

	typedef enum logic [2:0] {
		EV_RELEASED = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_HELD     = 3'd2,
		EV_CLICK    = 3'd3,
		EV_DOUBLE   = 3'd4,
		EV_UP       = 3'd5
	} bchc_event_t;

	localparam logic [CfgIdxW-1:0] REG_ACTIVE_LOW   = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_DEBOUNCE     = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_HOLD_TIMEOUT = 2'd2;
	localparam logic [CfgIdxW-1:0] REG_DOUBLE_CLICK = 2'd3;

	localparam logic [MsW-1:0] DEBOUNCE_RST     = 16'd50;
	localparam logic [MsW-1:0] HOLD_TIMEOUT_RST = 16'd500;
	localparam logic [MsW-1:0] DOUBLE_CLICK_RST = 16'd300;

	typedef struct packed {
		logic           active_low;
		logic [MsW-1:0] debounce_ms;
		logic [MsW-1:0] hold_timeout_ms;
		logic [MsW-1:0] double_click_ms;
	} bchc_cfg_t;

endpackage

// ----- hdl/bchc_core.sv -----
// Classifier state and the combinational next-state and event logic.
`timescale 1ns / 1ps
`include "button_click_hold_classifier_assert.svh"

module bchc_core
	import bchc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  logic             pin_level,
	input  logic [TimeW-1:0] now_ms,
	input  bchc_cfg_t        cfg,
	output bchc_event_t      event_next
);

	logic             stable_level_q;
	logic             debounce_pending_q;
	logic [TimeW-1:0] debounce_start_q;
	logic [TimeW-1:0] press_start_q;
	logic [TimeW-1:0] first_click_time_q;
	logic             click_pending_q;
	bchc_event_t      last_event_q;

	logic             stable_level_d;
	logic             debounce_pending_d;
	logic [TimeW-1:0] debounce_start_d;
	logic [TimeW-1:0] press_start_d;
	logic [TimeW-1:0] first_click_time_d;
	logic             click_pending_d;
	bchc_event_t      last_event_d;

	logic             level;
	logic             take_level;
	logic [TimeW-1:0] since_click;
	logic [TimeW-1:0] since_press;
	logic [TimeW-1:0] since_debounce;
	logic             in_window;

	// Differences wrap modulo 2^32 by plain unsigned subtraction.
	assign level          = pin_level ^ cfg.active_low;
	assign since_click    = now_ms - first_click_time_q;
	assign since_press    = now_ms - press_start_q;
	assign since_debounce = now_ms - debounce_start_q;
	assign in_window      = since_click <= {{(TimeW-MsW){1'b0}}, cfg.double_click_ms};

	always_comb begin
		stable_level_d     = stable_level_q;
		debounce_pending_d = debounce_pending_q;
		debounce_start_d   = debounce_start_q;
		press_start_d      = press_start_q;
		first_click_time_d = first_click_time_q;
		click_pending_d    = click_pending_q;
		last_event_d       = last_event_q;
		take_level         = 1'b0;

		if (level == stable_level_q) begin
			// A bounce back while a debounce is pending changes nothing.
			if (!debounce_pending_q) begin
				if (!level) begin
					last_event_d = EV_RELEASED;
					if (!in_window) begin
						click_pending_d = 1'b0;
					end
				end else if (since_press < {{(TimeW-MsW){1'b0}}, cfg.hold_timeout_ms}) begin
					last_event_d = EV_PRESSED;
				end else begin
					last_event_d = EV_HELD;
				end
			end
		end else if (cfg.debounce_ms != '0) begin
			if (!debounce_pending_q) begin
				debounce_start_d   = now_ms;
				debounce_pending_d = 1'b1;
			end else if (since_debounce >= {{(TimeW-MsW){1'b0}}, cfg.debounce_ms}) begin
				take_level = 1'b1;
			end
		end else begin
			take_level = 1'b1;
		end

		if (take_level) begin
			debounce_pending_d = 1'b0;
			stable_level_d     = level;
			if (level) begin
				press_start_d = now_ms;
				if (!click_pending_q) begin
					last_event_d       = EV_CLICK;
					click_pending_d    = 1'b1;
					first_click_time_d = now_ms;
				end else if (in_window) begin
					last_event_d    = EV_DOUBLE;
					click_pending_d = 1'b0;
				end
				// A late second press keeps the click pending and repeats the last event.
			end else begin
				last_event_d = EV_UP;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_level_q     <= 1'b0;
			debounce_pending_q <= 1'b0;
			debounce_start_q   <= '0;
			press_start_q      <= '0;
			first_click_time_q <= '0;
			click_pending_q    <= 1'b0;
			last_event_q       <= EV_RELEASED;
		end else if (step) begin
			stable_level_q     <= stable_level_d;
			debounce_pending_q <= debounce_pending_d;
			debounce_start_q   <= debounce_start_d;
			press_start_q      <= press_start_d;
			first_click_time_q <= first_click_time_d;
			click_pending_q    <= click_pending_d;
			last_event_q       <= last_event_d;
		end
	end

	assign event_next = last_event_d;

	`BCHC_ASSERT_IMPL(a_click_keeps_pending, last_event_q == EV_CLICK, click_pending_q, "click reported without a pending click")
	`BCHC_ASSERT_IMPL(a_double_clears_pending, last_event_q == EV_DOUBLE, !click_pending_q, "double click left a click pending")
	`BCHC_ASSERT_IMPL(a_pressed_is_stable_high, last_event_q == EV_PRESSED || last_event_q == EV_HELD, stable_level_q, "pressed or held reported while released")

endmodule

// ----- hdl/button_click_hold_classifier.sv -----
// Top level of the button click and hold classifier with handshakes and registers.
`timescale 1ns / 1ps
`include "button_click_hold_classifier_assert.svh"

// Classifies timestamped pin samples into released, pressed, held, click, double click and
// up events, with debounce and a double-click window. One sample may be accepted in every
// clock cycle while sample_stall is low; each yields one event, passing through the input
// register and then the event register. The rate is set by the state update, which
// evaluates each sample against the registered state (32-bit time subtractions and compares)
// combinationally. Configuration is written through the cfg channel, which is always ready;
// write it only while no samples are in flight.
module button_click_hold_classifier
	import bchc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  logic               pin_level,
	input  logic [TimeW-1:0]   now_ms,
	output logic               event_valid,
	input  logic               event_stall,
	output logic [2:0]         button_event,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [MsW-1:0]     cfg_data
);

	bchc_cfg_t        cfg_q;
	logic             valid_s1;
	logic             level_s1;
	logic [TimeW-1:0] now_s1;
	logic             event_valid_q;
	bchc_event_t      event_q;
	bchc_event_t      event_next;
	logic             advance;
	logic             step;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_low      <= 1'b0;
			cfg_q.debounce_ms     <= DEBOUNCE_RST;
			cfg_q.hold_timeout_ms <= HOLD_TIMEOUT_RST;
			cfg_q.double_click_ms <= DOUBLE_CLICK_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ACTIVE_LOW:   cfg_q.active_low      <= cfg_data[0];
				REG_DEBOUNCE:     cfg_q.debounce_ms     <= cfg_data;
				REG_HOLD_TIMEOUT: cfg_q.hold_timeout_ms <= cfg_data;
				REG_DOUBLE_CLICK: cfg_q.double_click_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The input register moves on whenever the event register is empty or being taken.
	assign advance      = !event_valid_q || !event_stall;
	assign step         = valid_s1 && advance;
	assign sample_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!sample_stall) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && !sample_stall) begin
			level_s1 <= pin_level;
			now_s1   <= now_ms;
		end
	end

	bchc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.pin_level  (level_s1),
		.now_ms     (now_s1),
		.cfg        (cfg_q),
		.event_next (event_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			event_valid_q <= 1'b0;
		end else if (advance) begin
			event_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			event_q <= event_next;
		end
	end

	assign event_valid  = event_valid_q;
	assign button_event = event_q;

	`BCHC_ASSERT_IMPL(a_stall_needs_full_pipe, sample_stall, valid_s1 && event_valid_q && event_stall, "input stalled while the pipeline can move")
	`BCHC_ASSERT_NEXT(a_step_gives_event, step, event_valid, "a processed sample produced no event")
	`BCHC_ASSERT_NEXT(a_debounce_write, cfg_valid && cfg_index == REG_DEBOUNCE, cfg_q.debounce_ms == $past(cfg_data), "debounce register write was lost")

endmodule
